// ===== rtl/assert_macros.svh =====
// Assertion helpers: clocked property with synchronous reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Overlapping implication: a |-> c
`define ASSERT_SAME(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication: a |=> c
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define ASSERT_SAME(label, clk, rst, a, c, msg)
`define ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

// ===== rtl/fpba_pkg.sv =====
`default_nettype none
package fpba_pkg;

   localparam int NUM_BLOCKS = 16;
   localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
   localparam int SIZE_W     = 16;
   localparam int CSR_W      = 5;

   // register indexes
   localparam logic CSR_FIT_MODE      = 1'b0;
   localparam logic CSR_BLOCKS_IN_USE = 1'b1;

   // request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_ALLOC = 1'b1;

   typedef enum logic [1:0] {
      MODE_FIRST = 2'd0,
      MODE_BEST  = 2'd1,
      MODE_WORST = 2'd2,
      MODE_SPARE = 2'd3
   } fit_mode_type;

   typedef enum logic [1:0] {
      ST_LOADED    = 2'd0,
      ST_ALLOCATED = 2'd1,
      ST_NOFIT     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_SCAN,
      S_WRITE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic              kind;
      logic [3:0]        load_index;
      logic [SIZE_W-1:0] load_size;
      logic [SIZE_W-1:0] request_size;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [3:0]        chosen_block;
      logic [SIZE_W-1:0] left_in_block;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/fpba_ram.sv =====
`default_nettype none
module fpba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/fit_policy_block_allocator.sv =====
// Load request: accepted in S_IDLE, written to the free-size RAM in S_LOAD, then
//   answered from S_FINISH into the registered rsp_valid once the output has room.
// Allocate request: S_SCAN reads N = blocks_in_use (saturated to NUM_BLOCKS) entries,
//   one read per cycle into a single compare unit; then S_WRITE, S_FINISH, S_IDLE.
// Reset (synchronous, active high): all free sizes read as zero (per-entry valid
//   bits cleared), fit_mode = first fit, blocks_in_use = 16, no response pending.
`default_nettype none
`include "assert_macros.svh"
module fit_policy_block_allocator
   import fpba_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire req_type          req_data,
   // response channel
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      rsp_type          rsp_data,
   // configuration writes
   input  wire logic             csr_wr_en,
   input  wire logic             csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   // ---------------------------------------------------------------
   // State
   // ---------------------------------------------------------------
   state_type          state_ff, state_in;
   fit_mode_type       mode_ff;
   logic [CSR_W-1:0]   blocks_ff;

   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;     // blocks searched this request
   logic [CNT_W-1:0]   issue_ff, issue_in;     // next RAM read index
   logic               pend_ff, pend_in;       // RAM read data arriving this cycle
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic               rd_vld_ff, rd_vld_in;   // entry was written since reset
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;
   logic [SIZE_W-1:0]  best_ff, best_in;       // size of current pick
   rsp_type            res_ff, res_in;         // finished result awaiting output reg
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [NUM_BLOCKS-1:0] valid_ff, valid_in;

   // RAM port signals
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [SIZE_W-1:0]  wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [SIZE_W-1:0]  rd_data;

   fpba_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------
   // Shared scan datapath
   // ---------------------------------------------------------------
   logic               req_fire;
   logic               out_room;
   logic               issue_go;
   logic               load_in_range;
   fit_mode_type       mode_eff;
   logic [SIZE_W-1:0]  scan_size;
   logic [SIZE_W-1:0]  cmp_lhs, cmp_rhs;
   logic               fits, better, take;
   logic [CNT_W-1:0]   count_sat;

   assign req_fire = req_valid && req_ready;
   assign out_room = !rsp_valid_ff || rsp_ready;
   assign issue_go = (state_ff == S_SCAN) && (issue_ff < count_ff);
   assign load_in_range = (32'(req_ff.load_index) < NUM_BLOCKS);

   // unused mode code behaves as first fit
   assign mode_eff = (mode_ff == MODE_SPARE) ? MODE_FIRST : mode_ff;

   // entries never written read as zero
   assign scan_size = rd_vld_ff ? rd_data : '0;
   assign fits      = (scan_size >= req_ff.request_size);

   // one magnitude compare; operands swap for worst fit (strict, so ties keep lower index)
   assign cmp_lhs = (mode_eff == MODE_WORST) ? best_ff : scan_size;
   assign cmp_rhs = (mode_eff == MODE_WORST) ? scan_size : best_ff;
   assign better  = (mode_eff != MODE_FIRST) && (cmp_lhs < cmp_rhs);
   assign take    = pend_ff && fits && (!found_ff || better);

   // saturate blocks_in_use to the table depth
   assign count_sat = (32'(blocks_ff) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(blocks_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (req_data.kind == KIND_LOAD) ? S_LOAD : S_SCAN;
            end
         end
         S_LOAD:  state_in = S_FINISH;
         S_SCAN: begin
            // last read data, if any, is folded in at this same edge
            if (!issue_go) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: state_in = S_FINISH;
         S_FINISH: begin
            if (out_room) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Datapath and outputs
   // ---------------------------------------------------------------
   always_comb begin
      req_in       = req_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      rd_vld_in    = rd_vld_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      valid_in     = valid_ff;

      wr_en   = 1'b0;
      wr_addr = pick_ff;
      wr_data = best_ff - req_ff.request_size;
      rd_en   = issue_go;
      rd_addr = IDX_W'(issue_ff);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in   = req_data;
               count_in = count_sat;
               issue_in = '0;
               found_in = 1'b0;
               pick_in  = '0;
               best_in  = '0;
            end
         end
         S_LOAD: begin
            wr_en   = load_in_range;
            wr_addr = IDX_W'(req_ff.load_index);
            wr_data = req_ff.load_size;
            res_in.status        = ST_LOADED;
            res_in.chosen_block  = req_ff.load_index;
            res_in.left_in_block = load_in_range ? req_ff.load_size : '0;
         end
         S_SCAN: begin
            if (issue_go) begin
               issue_in    = issue_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = IDX_W'(issue_ff);
               rd_vld_in   = valid_ff[rd_addr];
            end
            if (take) begin
               found_in = 1'b1;
               pick_in  = pend_idx_ff;
               best_in  = scan_size;
            end
         end
         S_WRITE: begin
            wr_en = found_ff;
            if (found_ff) begin
               res_in.status        = ST_ALLOCATED;
               res_in.chosen_block  = 4'(pick_ff);
               res_in.left_in_block = best_ff - req_ff.request_size;
            end else begin
               res_in.status        = ST_NOFIT;
               res_in.chosen_block  = '0;
               res_in.left_in_block = '0;
            end
         end
         S_FINISH: begin
            if (out_room) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_FIRST;
         blocks_ff    <= CSR_W'(16);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FIT_MODE:      mode_ff   <= fit_mode_type'(csr_wdata[1:0]);
               CSR_BLOCKS_IN_USE: blocks_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      count_ff    <= count_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      rd_vld_ff   <= rd_vld_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      best_ff     <= best_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, state_ff != S_IDLE, "accepted request left block idle")
   `ASSERT_SAME(a_pick_fits, clock, reset, (state_ff == S_WRITE) && found_ff, best_ff >= req_ff.request_size, "picked block smaller than request")
   `ASSERT_SAME(a_issue_bound, clock, reset, state_ff == S_SCAN, issue_ff <= count_ff, "scan index ran past blocks in use")
   `ASSERT_SAME(a_pend_in_scan, clock, reset, pend_ff, (state_ff == S_SCAN) || (state_ff == S_WRITE), "read data outside scan")

endmodule
`default_nettype wire
